### rtl/nsd_pkg.sv
// Shared types and constants for the netstring deframer.
package nsd_pkg;

    // Framing characters and digit range.
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Header limits and register defaults.
    localparam int          HEADER_LEN_DEF = 32;
    localparam int          LEN_W          = 64;
    localparam int          MAX_LEN_W      = 32;
    localparam logic [31:0] MAX_LEN_RESET  = 32'd65536;

    // Status reported with every result item.
    typedef enum logic [1:0] {
        ST_MORE      = 2'd0,
        ST_DONE      = 2'd1,
        ST_MALFORMED = 2'd2,
        ST_TOO_LARGE = 2'd3
    } status_t;

    // One result item.
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic       payload_last;
        status_t    status;
    } result_t;

endpackage

### rtl/nsd_stage.sv
// One-slot valid/ready pipeline register.
module nsd_stage #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         up_valid,
    output logic         up_ready,
    input  logic [W-1:0] up_data,
    output logic         dn_valid,
    input  logic         dn_ready,
    output logic [W-1:0] dn_data
);

    logic         valid_reg;
    logic [W-1:0] data_reg;

    // The slot takes a new item when empty or when its item leaves this cycle.
    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    // Data register carries no reset.
    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= up_data;
        end
    end

endmodule

### rtl/nsd_core.sv
// Deframing state and per-byte next-state logic.
module nsd_core #(
    parameter int HEADER_LEN = nsd_pkg::HEADER_LEN_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               step,
    input  logic [7:0]                         in_byte,
    input  logic [nsd_pkg::MAX_LEN_W-1:0]      max_length,
    output nsd_pkg::result_t                   result
);
    import nsd_pkg::*;

    localparam int HCW = (HEADER_LEN > 2) ? $clog2(HEADER_LEN) : 1;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_COMMA   = 2'd2
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [HCW-1:0]         hc_reg, hc_next;
    logic [LEN_W-1:0]       acc_reg, acc_next;
    logic [MAX_LEN_W-1:0]   rem_reg, rem_next;

    logic                   is_digit;
    logic [LEN_W+3:0]       acc_times10;
    logic                   acc_ovf;

    // Digit decode and length accumulate: acc * 10 + digit as shift-adds.
    assign is_digit    = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_NINE);
    assign acc_times10 = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                         + {(LEN_W + 4)'(in_byte[3:0])};
    assign acc_ovf     = |acc_times10[LEN_W+3:LEN_W];

    // Next state and result for the byte at the head of the pipe.
    always_comb
    begin
        phase_next = phase_reg;
        hc_next    = hc_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        result     = '{payload_byte: 8'd0, payload_valid: 1'b0,
                       payload_last: 1'b0, status: ST_MORE};
        case (phase_reg)
            PH_PAYLOAD:
            begin
                result.payload_byte  = in_byte;
                result.payload_valid = 1'b1;
                rem_next             = rem_reg - MAX_LEN_W'(1);
                if (rem_reg == MAX_LEN_W'(1))
                begin
                    result.payload_last = 1'b1;
                    phase_next          = PH_COMMA;
                end
            end
            PH_COMMA:
            begin
                result.status = (in_byte == CHAR_COMMA) ? ST_DONE : ST_MALFORMED;
                phase_next    = PH_HEADER;
                hc_next       = '0;
                acc_next      = '0;
                rem_next      = '0;
            end
            default:
            begin
                phase_next = PH_HEADER;
                if (is_digit)
                begin
                    if (acc_ovf || hc_reg == HCW'(HEADER_LEN - 1))
                    begin
                        result.status = ST_MALFORMED;
                        hc_next       = '0;
                        acc_next      = '0;
                        rem_next      = '0;
                    end
                    else
                    begin
                        acc_next = acc_times10[LEN_W-1:0];
                        hc_next  = hc_reg + HCW'(1);
                    end
                end
                else if (in_byte == CHAR_COLON && hc_reg != '0)
                begin
                    hc_next  = '0;
                    acc_next = '0;
                    if (acc_reg > {{(LEN_W - MAX_LEN_W){1'b0}}, max_length})
                    begin
                        result.status = ST_TOO_LARGE;
                        rem_next      = '0;
                    end
                    else
                    begin
                        rem_next   = acc_reg[MAX_LEN_W-1:0];
                        phase_next = (acc_reg == '0) ? PH_COMMA : PH_PAYLOAD;
                    end
                end
                else
                begin
                    result.status = ST_MALFORMED;
                    hc_next       = '0;
                    acc_next      = '0;
                    rem_next      = '0;
                end
            end
        endcase
    end

    // State registers advance once per processed item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            hc_reg    <= '0;
            acc_reg   <= '0;
            rem_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            hc_reg    <= hc_next;
            acc_reg   <= acc_next;
            rem_reg   <= rem_next;
        end
    end

endmodule

### rtl/netstring_deframer.sv
// Netstring deframer top level: input register, deframing core, result register.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+----------------------------------------------
//  cfg     | cfg_valid/cfg_ready  | cfg_data (max_length)
//  in      | in_valid/in_ready    | in_byte
//  out     | out_valid/out_ready  | payload_byte, payload_valid, payload_last, status
//
// One item per cycle sustained while out_ready is high; each item passes through
// the input register and then the result register, with the deframing logic
// between them.
// Reset clears the framing state to header phase and sets max_length to 65536.
// With out_ready low the result register holds; in_ready falls once both
// registers are full. cfg_ready is always high.
module netstring_deframer #(
    parameter int HEADER_LEN = nsd_pkg::HEADER_LEN_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [nsd_pkg::MAX_LEN_W-1:0]  cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [7:0]                     in_byte,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [7:0]                     payload_byte,
    output logic                           payload_valid,
    output logic                           payload_last,
    output nsd_pkg::status_t               status
);
    import nsd_pkg::*;

    logic [MAX_LEN_W-1:0]  max_length_reg;
    logic                  head_valid;
    logic                  head_ready;
    logic [7:0]            head_byte;
    result_t               core_result;
    logic [$bits(result_t)-1:0] out_data;
    result_t               out_result;

    // Configuration register, always ready.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= MAX_LEN_RESET;
        end
        else if (cfg_valid)
        begin
            max_length_reg <= cfg_data;
        end
    end

    // Input register.
    nsd_stage #(.W(8)) u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (in_valid),
        .up_ready (in_ready),
        .up_data  (in_byte),
        .dn_valid (head_valid),
        .dn_ready (head_ready),
        .dn_data  (head_byte)
    );

    // Deframing core; state moves when the item enters the result register.
    nsd_core #(.HEADER_LEN(HEADER_LEN)) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (head_valid && head_ready),
        .in_byte    (head_byte),
        .max_length (max_length_reg),
        .result     (core_result)
    );

    // Result register.
    nsd_stage #(.W($bits(result_t))) u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (head_valid),
        .up_ready (head_ready),
        .up_data  (core_result),
        .dn_valid (out_valid),
        .dn_ready (out_ready),
        .dn_data  (out_data)
    );

    // Unpack the result item onto the output ports.
    assign out_result    = result_t'(out_data);
    assign payload_byte  = out_result.payload_byte;
    assign payload_valid = out_result.payload_valid;
    assign payload_last  = out_result.payload_last;
    assign status        = out_result.status;

endmodule

### tb/netstring_deframer_checker.sv
// Checker for the netstring deframer: predicts each result item and compares it.
module netstring_deframer_checker #(
    parameter int HEADER_LEN = nsd_pkg::HEADER_LEN_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [nsd_pkg::MAX_LEN_W-1:0]  cfg_data,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic [7:0]                     in_byte,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [7:0]                     payload_byte,
    input  logic                           payload_valid,
    input  logic                           payload_last,
    input  nsd_pkg::status_t               status,
    output int                             errors,
    output int                             pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import nsd_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_COMMA   = 2'd2
    } frame_phase_t;

    // Predicted framing state and the register copy.
    frame_phase_t          frame_phase;
    logic [5:0]            digit_count;
    logic [LEN_W-1:0]      length_sum;
    logic [31:0]           bytes_left;
    logic [MAX_LEN_W-1:0]  max_length;

    result_t               expected_results[$];
    result_t               want;
    int                    mismatch_count;

    // Any error or finished netstring drops back to a fresh header.
    function automatic void restart_header();
        frame_phase = PH_HEADER;
        digit_count = '0;
        length_sum  = '0;
        bytes_left  = '0;
    endfunction

    // Header byte: accumulate a digit, or close the header on a colon.
    function automatic status_t take_header_byte(input logic [7:0] b);
        logic [LEN_W-1:0] digit;
        digit = LEN_W'(b - CHAR_ZERO);
        if (b >= CHAR_ZERO && b <= CHAR_NINE)
        begin
            if (length_sum > (64'hFFFF_FFFF_FFFF_FFFF - digit) / 64'd10)
            begin
                restart_header();
                return ST_MALFORMED;
            end
            length_sum  = length_sum * 64'd10 + digit;
            digit_count = digit_count + 6'd1;
            if (digit_count >= HEADER_LEN)
            begin
                restart_header();
                return ST_MALFORMED;
            end
            return ST_MORE;
        end
        if (b == CHAR_COLON && digit_count != 0)
        begin
            if (length_sum > {32'd0, max_length})
            begin
                restart_header();
                return ST_TOO_LARGE;
            end
            bytes_left  = length_sum[31:0];
            digit_count = '0;
            length_sum  = '0;
            frame_phase = (bytes_left == 0) ? PH_COMMA : PH_PAYLOAD;
            return ST_MORE;
        end
        restart_header();
        return ST_MALFORMED;
    endfunction

    // Work out the result item caused by one received byte.
    function automatic result_t deframe_byte(input logic [7:0] b);
        result_t r;
        r = '0;
        r.status = ST_MORE;
        case (frame_phase)
            PH_PAYLOAD:
            begin
                r.payload_byte  = b;
                r.payload_valid = 1'b1;
                bytes_left      = bytes_left - 32'd1;
                if (bytes_left == 0)
                begin
                    r.payload_last = 1'b1;
                    frame_phase    = PH_COMMA;
                end
            end
            PH_COMMA:
            begin
                r.status = (b == CHAR_COMMA) ? ST_DONE : ST_MALFORMED;
                restart_header();
            end
            default:
            begin
                frame_phase = PH_HEADER;
                r.status    = take_header_byte(b);
            end
        endcase
        return r;
    endfunction

    task automatic compare_field(input string what, input logic [7:0] exp_v,
                                 input logic [7:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, exp_v,
                     act_v);
            mismatch_count++;
        end
    endtask

    // Track the register, predict accepted bytes, compare accepted results.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_header();
            max_length = MAX_LEN_RESET;
            expected_results.delete();
            mismatch_count = 0;
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                max_length = cfg_data;
            if (in_valid && in_ready)
                expected_results.push_back(deframe_byte(in_byte));
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t ns: result item with none expected, actual %0h/%0b/%0b/%0d",
                             $time, payload_byte, payload_valid, payload_last, status);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("payload_byte", want.payload_byte, payload_byte);
                    compare_field("payload_valid", 8'(want.payload_valid), 8'(payload_valid));
                    compare_field("payload_last", 8'(want.payload_last), 8'(payload_last));
                    compare_field("status", 8'(want.status), 8'(status));
                end
            end
            errors  <= mismatch_count;
            pending <= expected_results.size();
        end
    end

endmodule

### tb/testbench.sv
// Top of the netstring deframer testbench: clock, reset, stimulus and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import nsd_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int HOLD_CYCLES  = 150;
    localparam int PHASE_ITEMS  = 150;
    localparam int PHASE_COUNT  = 6;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [MAX_LEN_W-1:0]  cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [7:0]            in_byte;
    logic                  out_valid;
    logic                  out_ready;
    logic [7:0]            payload_byte;
    logic                  payload_valid;
    logic                  payload_last;
    status_t               status;

    int                    errors;
    int                    pending;
    int                    sent_count;
    int                    gap_odds;
    int                    cycles;
    int                    phase_end;
    bit                    hold_req;
    logic [31:0]           cur_max;
    logic [31:0]           max_plan [PHASE_COUNT];

    netstring_deframer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_byte       (in_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .payload_byte  (payload_byte),
        .payload_valid (payload_valid),
        .payload_last  (payload_last),
        .status        (status)
    );

    netstring_deframer_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_byte       (in_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .payload_byte  (payload_byte),
        .payload_valid (payload_valid),
        .payload_last  (payload_last),
        .status        (status),
        .errors        (errors),
        .pending       (pending)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Watchdog on the total run length.
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Result side: random stall bursts, plus one long hold-off on request.
    initial
    begin
        out_ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        out_ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_ready <= 1'b1;
                hold_req = 1'b0;
            end
            else if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    // Offer one byte, after an occasional gap, and wait until it is taken.
    task automatic send_byte(input logic [7:0] b);
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent_count++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // Header and colon; the payload and trailer only when the length is accepted.
    task automatic send_frame(input string digits, input logic [63:0] plen, input bit body,
                              input bit comma_ok);
        logic [7:0] bad;
        send_text(digits);
        send_byte(CHAR_COLON);
        if (body)
        begin
            for (int i = 0; i < int'(plen); i++)
                send_byte(8'($urandom_range(0, 255)));
            bad = 8'($urandom_range(0, 255));
            if (bad == CHAR_COMMA)
                bad = CHAR_COLON;
            send_byte(comma_ok ? CHAR_COMMA : bad);
        end
    endtask

    // One random netstring, mostly well formed, otherwise broken or noise.
    task automatic random_frame();
        int          kind;
        int          pad;
        logic [63:0] len;
        logic [7:0]  b;
        string       digits;
        kind = int'($urandom_range(0, 99));
        if (kind < 65)
        begin
            len = ($urandom_range(0, 9) == 0) ? 64'($urandom_range(13, 48))
                                                : 64'($urandom_range(0, 12));
            if ($urandom_range(0, 7) == 0 && cur_max <= 48)
                len = {32'd0, cur_max};
            digits = $sformatf("%0d", len);
            pad = int'($urandom_range(0, 19));
            if (pad < 2)
                pad = 31 - digits.len();
            else if (pad < 6)
                pad = int'($urandom_range(1, 3));
            else
                pad = 0;
            repeat (pad) digits = {"0", digits};
            send_frame(digits, len, len <= {32'd0, cur_max}, $urandom_range(0, 15) != 0);
        end
        else if (kind < 77)
        begin
            // Lengths past the limit, up to the largest 64-bit value.
            if ($urandom_range(0, 5) == 0)
                len = 64'hFFFF_FFFF_FFFF_FFFF;
            else if (cur_max == 32'hFFFF_FFFF)
                len = 64'h1_0000_0000 + 64'($urandom_range(0, 9));
            else if ($urandom_range(0, 1) == 0)
                len = {32'd0, cur_max} + 64'd1 + 64'($urandom_range(0, 2));
            else
                len = {32'($urandom_range(1, 32'hFFFF_FFFF)), 32'($urandom)};
            send_frame($sformatf("%0d", len), len, 1'b0, 1'b0);
        end
        else if (kind < 83)
        begin
            // Lengths that no longer fit in 64 bits.
            if ($urandom_range(0, 1) == 0)
                send_text("18446744073709551616:");
            else
                send_text({"1844674407370955162", $sformatf("%0d:", $urandom_range(0, 9))});
        end
        else if (kind < 88)
        begin
            // Header that runs out of room before its colon.
            digits = "";
            repeat (31) digits = {digits, "0"};
            send_text({digits, $sformatf("%0d:", $urandom_range(0, 9))});
        end
        else if (kind < 94)
        begin
            // Stray character in the header, or a colon after zero to three digits.
            repeat ($urandom_range(0, 3)) send_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
            if ($urandom_range(0, 2) == 0)
            begin
                send_byte(CHAR_COLON);
            end
            else
            begin
                do
                    b = 8'($urandom_range(0, 255));
                while ((b >= CHAR_ZERO && b <= CHAR_NINE) || b == CHAR_COLON);
                send_byte(b);
            end
        end
        else
        begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // Stop offering and wait for every outstanding result item.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_max_length(input logic [31:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        cur_max = v;
    endtask

    initial
    begin
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        in_byte    = '0;
        hold_req   = 1'b0;
        gap_odds   = 6;
        sent_count = 0;
        cur_max    = MAX_LEN_RESET;
        max_plan   = '{32'd0, 32'hFFFF_FFFF, 32'd5, 32'($urandom_range(1, 48)),
                       32'($urandom), MAX_LEN_RESET};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed cases under the reset limit.
        send_text("0:,");
        send_text(":");
        send_text("1:");
        send_byte(8'h00);
        send_byte(CHAR_COMMA);
        send_text("2:");
        send_byte(8'hFF);
        send_byte(8'h7F);
        send_byte(CHAR_COMMA);
        send_text("7x");
        send_byte(8'hFF);
        send_text("1:a;");
        send_text("65537:");
        drain();

        // Random netstrings under a series of limits; the last part runs without gaps.
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            write_max_length(max_plan[p]);
            if (p == PHASE_COUNT - 1)
                gap_odds = 0;
            else
                gap_odds = (p % 3 == 0) ? 3 : ((p % 3 == 1) ? 8 : 20);
            if (p == 2)
                hold_req = 1'b1;
            phase_end = sent_count + PHASE_ITEMS;
            while (sent_count < phase_end)
                random_frame();
            drain();
        end

        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### files.f
rtl/nsd_pkg.sv
rtl/nsd_stage.sv
rtl/nsd_core.sv
rtl/netstring_deframer.sv
tb/netstring_deframer_checker.sv
tb/testbench.sv
